// ===== hw/rtl/hsv_color_key_mask_core_assert.svh =====
// Assertion macros shared by the HSV color key mask RTL.
`ifndef HSV_COLOR_KEY_MASK_CORE_ASSERT_SVH
`define HSV_COLOR_KEY_MASK_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define HCK_ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!(rst_sig)) \
        (ante) |-> (cons)) else $error("hck assertion failed");
`define HCK_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!(rst_sig)) \
        (ante) |=> (cons)) else $error("hck assertion failed");
`else
`define HCK_ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons)
`define HCK_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons)
`endif

`endif

// ===== hw/rtl/hck_pkg.sv =====
// Types and constants of the HSV color key mask.
package hck_pkg;

    localparam int COMP_W     = 8;
    localparam int DIV_NUM_W  = 23;
    localparam int QUO_W      = 15;
    localparam int HUE_W      = 16;
    localparam int SAT_W      = 13;
    localparam int HUE_WIN_W  = 15;
    localparam int SAT_WIN_W  = 13;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 15;

    localparam int DIV_STEPS_PER_STAGE = 4;
    localparam int PREP_STAGES         = 2;
    localparam int MATCH_STAGES        = 2;

    localparam logic [HUE_WIN_W-1:0] HUE_WIN_RESET = 15'd640;
    localparam logic [SAT_WIN_W-1:0] SAT_WIN_RESET = 13'd410;
    localparam logic [COMP_W-1:0]    MASK_HIT      = 8'hFF;
    localparam logic [COMP_W-1:0]    MASK_MISS     = 8'h00;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TARGET_RED   = 3'd0,
        REG_TARGET_GREEN = 3'd1,
        REG_TARGET_BLUE  = 3'd2,
        REG_HUE_WINDOW   = 3'd3,
        REG_SAT_WINDOW   = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_sel_t;

    typedef struct packed {
        logic [COMP_W-1:0] pixel_red;
        logic [COMP_W-1:0] pixel_green;
        logic [COMP_W-1:0] pixel_blue;
        logic              last_in_frame;
    } pixel_t;

    typedef struct packed {
        logic [COMP_W-1:0] mask_value;
        logic              mask_last;
    } mask_t;

    typedef struct packed {
        logic [DIV_NUM_W-1:0] hue_num;
        logic [COMP_W-1:0]    hue_den;
        logic [DIV_NUM_W-1:0] sat_num;
        logic [COMP_W-1:0]    sat_den;
    } div_req_t;

    typedef struct packed {
        logic hue_neg;
        logic hue_zero;
        logic sat_zero;
    } hsv_flags_t;

endpackage

// ===== hw/rtl/hck_prep.sv =====
// Front end: max, min and span of one color, then the hue and saturation dividends.
module hck_prep
    import hck_pkg::*;
(
    input  logic              clk,
    input  logic [COMP_W-1:0] red,
    input  logic [COMP_W-1:0] green,
    input  logic [COMP_W-1:0] blue,
    output div_req_t          req,
    output hsv_flags_t        flags
);

    logic [COMP_W-1:0] max_next;
    logic [COMP_W-1:0] min_next;
    logic [COMP_W-1:0] diff_next;
    max_sel_t          sel_next;

    logic [COMP_W-1:0] red_reg;
    logic [COMP_W-1:0] green_reg;
    logic [COMP_W-1:0] blue_reg;
    logic [COMP_W-1:0] max_reg;
    logic [COMP_W-1:0] diff_reg;
    max_sel_t          sel_reg;

    logic [11:0]       span;
    logic [11:0]       mag;
    div_req_t          req_next;
    hsv_flags_t        flags_next;
    div_req_t          req_reg;
    hsv_flags_t        flags_reg;

    always_comb
    begin
        max_next = red;
        if (green > max_next)
        begin
            max_next = green;
        end
        if (blue > max_next)
        begin
            max_next = blue;
        end
        min_next = red;
        if (green < min_next)
        begin
            min_next = green;
        end
        if (blue < min_next)
        begin
            min_next = blue;
        end
        diff_next = max_next - min_next;

        // Ties on the maximum go to red, then green, then blue.
        if (red == max_next)
        begin
            sel_next = MAX_RED;
        end
        else if (green == max_next)
        begin
            sel_next = MAX_GREEN;
        end
        else
        begin
            sel_next = MAX_BLUE;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red;
        green_reg <= green;
        blue_reg  <= blue;
        max_reg   <= max_next;
        diff_reg  <= diff_next;
        sel_reg   <= sel_next;
    end

    // The sector offsets of 120 and 240 degrees are folded into the dividend as
    // 2*d and 4*d, so only the red sector can give a negative hue.
    always_comb
    begin
        case (sel_reg)
            MAX_RED:
                span = {4'b0, green_reg} - {4'b0, blue_reg};
            MAX_GREEN:
                span = {4'b0, blue_reg} - {4'b0, red_reg} + {3'b0, diff_reg, 1'b0};
            MAX_BLUE:
                span = {4'b0, red_reg} - {4'b0, green_reg} + {2'b0, diff_reg, 2'b0};
            default:
                span = '0;
        endcase
        mag = span[11] ? 12'(-span) : span;

        // Multiply by 3840 as 4096 minus 256.
        req_next.hue_num = {mag[10:0], 12'b0} - {4'b0, mag[10:0], 8'b0};
        req_next.hue_den = diff_reg;
        req_next.sat_num = {3'b0, diff_reg, 12'b0};
        req_next.sat_den = max_reg;

        flags_next.hue_neg  = span[11];
        flags_next.hue_zero = (diff_reg == '0);
        flags_next.sat_zero = (max_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        flags_reg <= flags_next;
    end

    assign req   = req_reg;
    assign flags = flags_reg;

endmodule

// ===== hw/rtl/hck_div.sv =====
// Pipelined restoring divider with an 8-bit divisor, several quotient bits per stage.
module hck_div
    import hck_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int QW    = QUO_W,
    parameter int STEPS = DIV_STEPS_PER_STAGE
)
(
    input  logic              clk,
    input  logic [NUM_W-1:0]  num,
    input  logic [COMP_W-1:0] den,
    output logic [QW-1:0]     quo
);

    localparam int STAGES = (NUM_W + STEPS - 1) / STEPS;
    localparam int PAD_W  = STAGES * STEPS;

    logic [PAD_W-1:0]  n_in   [STAGES];
    logic [COMP_W-1:0] r_in   [STAGES];
    logic [QW-1:0]     q_in   [STAGES];
    logic [COMP_W-1:0] d_in   [STAGES];

    logic [PAD_W-1:0]  n_next [STAGES];
    logic [COMP_W-1:0] r_next [STAGES];
    logic [QW-1:0]     q_next [STAGES];

    logic [PAD_W-1:0]  n_reg  [STAGES];
    logic [COMP_W-1:0] r_reg  [STAGES];
    logic [QW-1:0]     q_reg  [STAGES];
    logic [COMP_W-1:0] d_reg  [STAGES];

    always_comb
    begin
        n_in[0] = PAD_W'(num);
        r_in[0] = '0;
        q_in[0] = '0;
        d_in[0] = den;
        for (int s = 1; s < STAGES; s++)
        begin
            n_in[s] = n_reg[s-1];
            r_in[s] = r_reg[s-1];
            q_in[s] = q_reg[s-1];
            d_in[s] = d_reg[s-1];
        end
    end

    // The partial remainder stays below the divisor, so a 9-bit trial suffices.
    always_comb
    begin
        logic [PAD_W-1:0]  n;
        logic [COMP_W-1:0] r;
        logic [QW-1:0]     q;
        logic [COMP_W:0]   trial;
        for (int s = 0; s < STAGES; s++)
        begin
            n = n_in[s];
            r = r_in[s];
            q = q_in[s];
            for (int k = 0; k < STEPS; k++)
            begin
                trial = {r, n[PAD_W-1]};
                n     = {n[PAD_W-2:0], 1'b0};
                if (trial >= {1'b0, d_in[s]})
                begin
                    r = COMP_W'(trial - {1'b0, d_in[s]});
                    q = QW'({q, 1'b1});
                end
                else
                begin
                    r = trial[COMP_W-1:0];
                    q = QW'({q, 1'b0});
                end
            end
            n_next[s] = n;
            r_next[s] = r;
            q_next[s] = q;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            n_reg[s] <= n_next[s];
            r_reg[s] <= r_next[s];
            q_reg[s] <= q_next[s];
            d_reg[s] <= d_in[s];
        end
    end

    assign quo = q_reg[STAGES-1];

endmodule

// ===== hw/rtl/hck_match.sv =====
// Back end: signed hue and saturation for pixel and target, then the window compare.
module hck_match
    import hck_pkg::*;
(
    input  logic                 clk,
    input  logic [QUO_W-1:0]     pix_hue_q,
    input  logic [QUO_W-1:0]     pix_sat_q,
    input  hsv_flags_t           pix_flags,
    input  logic [QUO_W-1:0]     tgt_hue_q,
    input  logic [QUO_W-1:0]     tgt_sat_q,
    input  hsv_flags_t           tgt_flags,
    input  logic [HUE_WIN_W-1:0] hue_window,
    input  logic [SAT_WIN_W-1:0] sat_window,
    output logic                 hit
);

    function automatic logic [HUE_W-1:0] fmt_hue(input logic [QUO_W-1:0] q,
                                                 input hsv_flags_t f);
        logic [HUE_W-1:0] mag;
        mag = {1'b0, q};
        if (f.hue_zero)
        begin
            return '0;
        end
        return f.hue_neg ? HUE_W'(-mag) : mag;
    endfunction

    function automatic logic [SAT_W-1:0] fmt_sat(input logic [QUO_W-1:0] q,
                                                 input hsv_flags_t f);
        return f.sat_zero ? '0 : q[SAT_W-1:0];
    endfunction

    logic signed [HUE_W-1:0] pix_hue_reg;
    logic signed [HUE_W-1:0] tgt_hue_reg;
    logic [SAT_W-1:0]        pix_sat_reg;
    logic [SAT_W-1:0]        tgt_sat_reg;

    logic signed [17:0]      hue_lo;
    logic signed [17:0]      hue_hi;
    logic signed [17:0]      hue_pix;
    logic signed [14:0]      sat_lo;
    logic signed [14:0]      sat_hi;
    logic signed [14:0]      sat_pix;
    logic                    hit_next;
    logic                    hit_reg;

    always_ff @(posedge clk)
    begin
        pix_hue_reg <= fmt_hue(pix_hue_q, pix_flags);
        tgt_hue_reg <= fmt_hue(tgt_hue_q, tgt_flags);
        pix_sat_reg <= fmt_sat(pix_sat_q, pix_flags);
        tgt_sat_reg <= fmt_sat(tgt_sat_q, tgt_flags);
    end

    always_comb
    begin
        hue_pix  = 18'(pix_hue_reg);
        hue_lo   = 18'(tgt_hue_reg) - 18'(hue_window);
        hue_hi   = 18'(tgt_hue_reg) + 18'(hue_window);
        sat_pix  = 15'(pix_sat_reg);
        sat_lo   = 15'(tgt_sat_reg) - 15'(sat_window);
        sat_hi   = 15'(tgt_sat_reg) + 15'(sat_window);
        // Both bounds are open, so a zero window never matches.
        hit_next = (hue_lo < hue_pix) && (hue_pix < hue_hi) &&
                   (sat_lo < sat_pix) && (sat_pix < sat_hi);
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    assign hit = hit_reg;

endmodule

// ===== hw/rtl/hsv_color_key_mask_core.sv =====
// Top level of the HSV color key mask: configuration registers, lanes and timing.
//
// The core takes one RGB pixel in every clock cycle (busy never rises) and
// returns its 8-bit key mask, 255 or 0, with the frame-end flag, registered
// through the prep, divider and match stages (four quotient bits per divider
// stage by default). The restoring dividers form the pixel and target hue and
// saturation in parallel. Each result is on mask for the single cycle in which
// mask_valid is high; the receiver cannot stall the core and must take every
// transfer. A write to the target color, which takes effect for pixels started
// after it, or to a window, which also reaches pixels in flight, is to be made
// by the user only while no pixel is in flight; the core does not enforce this.
`include "hsv_color_key_mask_core_assert.svh"

module hsv_color_key_mask_core
    import hck_pkg::*;
#(
    parameter int STEPS_PER_STAGE = DIV_STEPS_PER_STAGE
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start,
    input  pixel_t                pixel,
    output logic                  busy,
    output logic                  mask_valid,
    output mask_t                 mask
);

    localparam int DIV_STAGES = (DIV_NUM_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int LATENCY    = PREP_STAGES + DIV_STAGES + MATCH_STAGES;

    logic [COMP_W-1:0]    target_red_reg;
    logic [COMP_W-1:0]    target_green_reg;
    logic [COMP_W-1:0]    target_blue_reg;
    logic [HUE_WIN_W-1:0] hue_window_reg;
    logic [SAT_WIN_W-1:0] sat_window_reg;

    logic                 accept;
    logic                 valid_reg [LATENCY];
    logic                 last_reg  [LATENCY];

    div_req_t             pix_req;
    div_req_t             tgt_req;
    hsv_flags_t           pix_flags;
    hsv_flags_t           tgt_flags;
    hsv_flags_t           pix_flags_reg [DIV_STAGES];
    hsv_flags_t           tgt_flags_reg [DIV_STAGES];

    logic [QUO_W-1:0]     pix_hue_q;
    logic [QUO_W-1:0]     pix_sat_q;
    logic [QUO_W-1:0]     tgt_hue_q;
    logic [QUO_W-1:0]     tgt_sat_q;
    logic                 hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_red_reg   <= '0;
            target_green_reg <= '0;
            target_blue_reg  <= '0;
            hue_window_reg   <= HUE_WIN_RESET;
            sat_window_reg   <= SAT_WIN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                REG_TARGET_RED:   target_red_reg   <= cfg_data[COMP_W-1:0];
                REG_TARGET_GREEN: target_green_reg <= cfg_data[COMP_W-1:0];
                REG_TARGET_BLUE:  target_blue_reg  <= cfg_data[COMP_W-1:0];
                REG_HUE_WINDOW:   hue_window_reg   <= cfg_data[HUE_WIN_W-1:0];
                REG_SAT_WINDOW:   sat_window_reg   <= cfg_data[SAT_WIN_W-1:0];
                default:          ;
            endcase
        end
    end

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LATENCY; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= accept;
            for (int i = 1; i < LATENCY; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg[0] <= pixel.last_in_frame;
        for (int i = 1; i < LATENCY; i++)
        begin
            last_reg[i] <= last_reg[i-1];
        end
        pix_flags_reg[0] <= pix_flags;
        tgt_flags_reg[0] <= tgt_flags;
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            pix_flags_reg[i] <= pix_flags_reg[i-1];
            tgt_flags_reg[i] <= tgt_flags_reg[i-1];
        end
    end

    // The target runs through its own lane beside every pixel, so a new key
    // color is ready for the first pixel that follows the write.
    hck_prep u_pix_prep (
        .clk   (clk),
        .red   (pixel.pixel_red),
        .green (pixel.pixel_green),
        .blue  (pixel.pixel_blue),
        .req   (pix_req),
        .flags (pix_flags)
    );

    hck_prep u_tgt_prep (
        .clk   (clk),
        .red   (target_red_reg),
        .green (target_green_reg),
        .blue  (target_blue_reg),
        .req   (tgt_req),
        .flags (tgt_flags)
    );

    hck_div #(.NUM_W(DIV_NUM_W), .QW(QUO_W), .STEPS(STEPS_PER_STAGE)) u_pix_hue_div (
        .clk (clk),
        .num (pix_req.hue_num),
        .den (pix_req.hue_den),
        .quo (pix_hue_q)
    );

    hck_div #(.NUM_W(DIV_NUM_W), .QW(QUO_W), .STEPS(STEPS_PER_STAGE)) u_pix_sat_div (
        .clk (clk),
        .num (pix_req.sat_num),
        .den (pix_req.sat_den),
        .quo (pix_sat_q)
    );

    hck_div #(.NUM_W(DIV_NUM_W), .QW(QUO_W), .STEPS(STEPS_PER_STAGE)) u_tgt_hue_div (
        .clk (clk),
        .num (tgt_req.hue_num),
        .den (tgt_req.hue_den),
        .quo (tgt_hue_q)
    );

    hck_div #(.NUM_W(DIV_NUM_W), .QW(QUO_W), .STEPS(STEPS_PER_STAGE)) u_tgt_sat_div (
        .clk (clk),
        .num (tgt_req.sat_num),
        .den (tgt_req.sat_den),
        .quo (tgt_sat_q)
    );

    hck_match u_match (
        .clk        (clk),
        .pix_hue_q  (pix_hue_q),
        .pix_sat_q  (pix_sat_q),
        .pix_flags  (pix_flags_reg[DIV_STAGES-1]),
        .tgt_hue_q  (tgt_hue_q),
        .tgt_sat_q  (tgt_sat_q),
        .tgt_flags  (tgt_flags_reg[DIV_STAGES-1]),
        .hue_window (hue_window_reg),
        .sat_window (sat_window_reg),
        .hit        (hit)
    );

    assign mask_valid      = valid_reg[LATENCY-1];
    assign mask.mask_value = hit ? MASK_HIT : MASK_MISS;
    assign mask.mask_last  = last_reg[LATENCY-1];

    `HCK_ASSERT_IMPLY(a_transfer_returns, clk, rst_n, accept, ##LATENCY mask_valid)
    `HCK_ASSERT_IMPLY(a_no_spurious_result, clk, rst_n, mask_valid,
        $past(accept, LATENCY))
    `HCK_ASSERT_NEXT(a_zero_hue_window_misses, clk, rst_n,
        valid_reg[LATENCY-2] && (hue_window_reg == '0), mask.mask_value == MASK_MISS)
    `HCK_ASSERT_NEXT(a_zero_sat_window_misses, clk, rst_n,
        valid_reg[LATENCY-2] && (sat_window_reg == '0), mask.mask_value == MASK_MISS)

endmodule
